// ===== rtl/button_debounce_click_classifier_top_defines.svh =====
// ----------------------------------------------------------------------------
// Button debounce click classifier assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button debounce click classifier package
// Widths, register indexes, reset values, phase and event codes.
// ----------------------------------------------------------------------------
package bdc_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PHASE_W    = 3;
    localparam int EVENT_W    = 2;
    localparam int TOTAL_W    = 3;

    // default press count limit
    localparam int MAX_PRESSES_DEF = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd3;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] SETTLE_RST = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LONG_RST   = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] GAP_RST    = 16'd400;
    localparam logic                  ACTIVE_RST = 1'b1;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRESS   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd4;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_LONG  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_MULTI = 2'd2;

endpackage

// ===== rtl/button_debounce_click_classifier_top.sv =====
// ----------------------------------------------------------------------------
// Button debounce click classifier
// Debounces polled switch samples and classifies long and multi presses.
// ----------------------------------------------------------------------------
// Each request carries a raw switch level and a millisecond timestamp and
// yields exactly one result: the debounced level, an event code and a press
// count. One request is taken per clock cycle while the input register is
// free or the result register can advance. A request is captured in the
// input register when accepted and moves to the result register when that
// register is empty or is being taken by a ready output side. A stalled
// result holds the input register, and new requests wait only while both
// registers are full. The rate is set by the single classify stage, whose
// state updates with one 32-bit subtract and compare per timer.
// Configuration writes via cfg_we take effect at once and are to be made
// only while the block is idle; the block itself does not enforce this.
`include "button_debounce_click_classifier_top_defines.svh"

module button_debounce_click_classifier_top #(
    parameter int MAX_PRESSES = bdc_pkg::MAX_PRESSES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [bdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdc_pkg::CFG_DATA_W-1:0] cfg_data,
    // poll requests
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           raw_level,
    input  logic [bdc_pkg::TIME_W-1:0]     now_ms,
    // results
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           clean_level,
    output logic [bdc_pkg::EVENT_W-1:0]    event_kind,
    output logic [bdc_pkg::TOTAL_W-1:0]    press_total
);
    import bdc_pkg::*;

    localparam int TALLY_W = $clog2(MAX_PRESSES + 1);
    localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_PRESSES);
    localparam logic [TALLY_W-1:0] TALLY_ONE = TALLY_W'(1);

    // configuration registers
    logic [CFG_DATA_W-1:0] settle_reg;
    logic [CFG_DATA_W-1:0] long_reg;
    logic [CFG_DATA_W-1:0] gap_reg;
    logic                  active_reg;

    // input stage
    logic              stg_valid_reg;
    logic              stg_raw_reg;
    logic [TIME_W-1:0] stg_now_reg;

    // classifier state
    logic               stable_reg, stable_next;
    logic               last_raw_reg;
    logic [TIME_W-1:0]  last_change_reg, last_change_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [TIME_W-1:0]  press_start_reg, press_start_next;
    logic [TIME_W-1:0]  release_reg, release_next;

    // result register
    logic               out_valid_reg;
    logic               clean_reg;
    logic [EVENT_W-1:0] event_reg, event_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic                       advance;
    logic                       changed;
    logic                       pressed;
    logic [TIME_W-1:0]          elapsed;
    logic [TIME_W-1:0]          held_span;
    logic [TIME_W-1:0]          gap_time;
    logic [TALLY_W+TOTAL_W-1:0] tally_ext;

    // handshake
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !stg_valid_reg || advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_RST;
            long_reg   <= LONG_RST;
            gap_reg    <= GAP_RST;
            active_reg <= ACTIVE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SETTLE: settle_reg <= cfg_data;
                CFG_LONG:   long_reg   <= cfg_data;
                CFG_GAP:    gap_reg    <= cfg_data;
                CFG_ACTIVE: active_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_raw_reg <= raw_level;
            stg_now_reg <= now_ms;
        end
    end

    // debounce
    always_comb
    begin
        changed          = stg_raw_reg != last_raw_reg;
        elapsed          = changed ? '0 : stg_now_reg - last_change_reg;
        last_change_next = changed ? stg_now_reg : last_change_reg;
        stable_next      = (elapsed > TIME_W'(settle_reg)) ? stg_raw_reg : stable_reg;
        pressed          = stable_next == active_reg;
    end

    // phase machine
    always_comb
    begin
        held_span        = stg_now_reg - press_start_reg;
        gap_time         = stg_now_reg - release_reg;
        tally_ext        = {{TOTAL_W{1'b0}}, tally_reg};
        phase_next       = phase_reg;
        tally_next       = tally_reg;
        press_start_next = press_start_reg;
        release_next     = release_reg;
        event_next       = EV_NONE;
        total_next       = '0;
        unique case (phase_reg)
            PH_PRESS:
            begin
                press_start_next = stg_now_reg;
                if (tally_reg < TALLY_MAX)
                begin
                    tally_next = tally_reg + TALLY_ONE;
                end
                phase_next = PH_HOLD;
            end
            PH_HOLD:
            begin
                if (!pressed)
                begin
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                release_next = stg_now_reg;
                if (held_span > TIME_W'(long_reg) && tally_reg == TALLY_ONE)
                begin
                    event_next = EV_LONG;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (gap_time < TIME_W'(gap_reg))
                begin
                    if (pressed)
                    begin
                        phase_next = PH_PRESS;
                    end
                end
                else
                begin
                    event_next = EV_MULTI;
                    total_next = tally_ext[TOTAL_W-1:0];
                    phase_next = PH_IDLE;
                end
            end
            // idle and unused codes
            default:
            begin
                tally_next       = '0;
                press_start_next = '0;
                release_next     = '0;
                phase_next       = pressed ? PH_PRESS : PH_IDLE;
            end
        endcase
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= 1'b0;
            last_raw_reg    <= 1'b0;
            last_change_reg <= '0;
            phase_reg       <= PH_IDLE;
            tally_reg       <= '0;
            press_start_reg <= '0;
            release_reg     <= '0;
        end
        else if (stg_valid_reg && advance)
        begin
            stable_reg      <= stable_next;
            last_raw_reg    <= stg_raw_reg;
            last_change_reg <= last_change_next;
            phase_reg       <= phase_next;
            tally_reg       <= tally_next;
            press_start_reg <= press_start_next;
            release_reg     <= release_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stg_valid_reg;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (stg_valid_reg && advance)
        begin
            clean_reg <= stable_next;
            event_reg <= event_next;
            total_reg <= total_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign clean_level = clean_reg;
    assign event_kind  = event_reg;
    assign press_total = total_reg;

    // checks
    `BDC_ASSERT_NOW(a_total_only_multi, out_valid_reg && event_reg != EV_MULTI, total_reg == '0, "press total outside multi press event")
    `BDC_ASSERT_NOW(a_tally_bound, 1'b1, tally_reg <= TALLY_MAX, "press tally above limit")
    `BDC_ASSERT_NOW(a_hold_has_press, phase_reg == PH_HOLD || phase_reg == PH_RELEASE, tally_reg != '0, "hold without counted press")
    `BDC_ASSERT_NEXT(a_stage_kept, stg_valid_reg && !advance, stg_valid_reg && $stable(stg_now_reg), "stalled request lost")

endmodule
